// ===== rtl/svna_pkg.sv =====
// Package for the sparse voxel normal accumulator.
// Holds config register indexes, status codes and shared record types.
// No dependencies.
package svna_pkg;

    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 32;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_MIN_X   = 3'd0,
        REG_MIN_Y   = 3'd1,
        REG_MIN_Z   = 3'd2,
        REG_INV     = 3'd3,
        REG_CELLS_X = 3'd4,
        REG_CELLS_Y = 3'd5,
        REG_CELLS_Z = 3'd6
    } cfg_addr_t;

    typedef enum logic [1:0] {
        ST_UPDATED = 2'd0,
        ST_NEW     = 2'd1,
        ST_OUTSIDE = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef struct packed {
        logic [15:0]        hits;
        logic signed [31:0] sum_x;
        logic signed [31:0] sum_y;
        logic signed [31:0] sum_z;
    } voxel_acc_t;

    function automatic logic signed [31:0] sat_add(logic signed [31:0] a,
                                                   logic signed [15:0] b);
        logic signed [32:0] s;
        begin
            s = 33'(a) + 33'(b);
            if (s > 33'sd2147483647) begin
                sat_add = 32'sh7fffffff;
            end else if (s < -33'sd2147483648) begin
                sat_add = 32'sh80000000;
            end else begin
                sat_add = s[31:0];
            end
        end
    endfunction

endpackage

// ===== rtl/sparse_voxel_normal_accumulator_top.sv =====
// Top level of the sparse voxel normal accumulator: quantizers, chain of
// table cells, sequencer and output register. Depends on svna_pkg.
//
// channel  | ports             | content
// s_axis   | s_tvalid/tready   | tdata: point_x,y,z, normal_x,y,z
// m_axis   | m_tvalid/tready   | tdata: status, slot, voxel_x,y,z, hits, total_x,y,z
// cfg      | cfg_we/addr/data  | seven registers
//
// Each item passes through accept, the quantizer, the walk, the write and the
// result state in that order; when no cell matches, the walk probes every
// cell. A point outside the grid skips walk and write.
// Reset clears the fill count and the valid flags.
// A pending result holds its register until transferred; no new item is
// taken until then.
module sparse_voxel_normal_accumulator_top
    import svna_pkg::*;
#(
    parameter int CAPACITY   = 256,
    parameter int INDEX_BITS = 10
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // point_x[31:0] point_y[63:32] point_z[95:64] normal_x[111:96]
    // normal_y[127:112] normal_z[143:128]
    input  logic [143:0]             s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // status[1:0] slot[9:2] voxel_x[19:10] voxel_y[29:20] voxel_z[39:30]
    // hits[55:40] total_x[87:56] total_y[119:88] total_z[151:120]
    output logic [151:0]             m_tdata,
    input  logic                     cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);
    localparam int KEY_BITS  = 3 * INDEX_BITS;
    localparam int SLOT_BITS = $clog2(CAPACITY);
    localparam int CNT_BITS  = $clog2(CAPACITY + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_QUANT = 5'b00010,
        S_WALK  = 5'b00100,
        S_WRITE = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t state_reg;
    logic [31:0] min_x_reg, min_y_reg, min_z_reg, inv_reg;
    logic [10:0] cx_reg, cy_reg, cz_reg;
    logic [143:0] in_reg;
    logic [1:0]  qcnt_reg;
    logic [CNT_BITS-1:0] used_reg, step_reg;
    logic [INDEX_BITS-1:0] ix, iy, iz;
    logic inx, iny, inz;
    logic [KEY_BITS-1:0] key_reg;
    logic [INDEX_BITS-1:0] vx_reg, vy_reg, vz_reg;
    logic found_reg;
    logic [SLOT_BITS-1:0] fslot_reg;
    logic [CAPACITY-1:0] hit_vec, load_vec, upd_vec;
    voxel_acc_t acc_vec [CAPACITY];
    logic [1:0] st_reg;
    logic [SLOT_BITS-1:0] oslot_reg;
    voxel_acc_t oacc_reg;
    logic [CAPACITY-1:0] probe_chain_reg;
    logic [7:0] slot8;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_x_reg <= '0; min_y_reg <= '0; min_z_reg <= '0;
            inv_reg <= 32'd65536;
            cx_reg <= 11'd1024; cy_reg <= 11'd1024; cz_reg <= 11'd1024;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_MIN_X:   min_x_reg <= cfg_data;
                REG_MIN_Y:   min_y_reg <= cfg_data;
                REG_MIN_Z:   min_z_reg <= cfg_data;
                REG_INV:     inv_reg   <= cfg_data;
                REG_CELLS_X: cx_reg    <= cfg_data[10:0];
                REG_CELLS_Y: cy_reg    <= cfg_data[10:0];
                REG_CELLS_Z: cz_reg    <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    svna_quant #(.INDEX_BITS(INDEX_BITS)) u_qx (.aclk, .point(in_reg[31:0]),
        .grid_min(min_x_reg), .inverse(inv_reg), .cells(cx_reg), .index(ix), .in_grid(inx));
    svna_quant #(.INDEX_BITS(INDEX_BITS)) u_qy (.aclk, .point(in_reg[63:32]),
        .grid_min(min_y_reg), .inverse(inv_reg), .cells(cy_reg), .index(iy), .in_grid(iny));
    svna_quant #(.INDEX_BITS(INDEX_BITS)) u_qz (.aclk, .point(in_reg[95:64]),
        .grid_min(min_z_reg), .inverse(inv_reg), .cells(cz_reg), .index(iz), .in_grid(inz));

    // probe token walks the chain, one cell per cycle
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            assign load_vec[g] = (state_reg == S_WRITE) && !found_reg &&
                                 (used_reg == CNT_BITS'(g)) && (st_reg == ST_NEW);
            assign upd_vec[g]  = (state_reg == S_WRITE) && found_reg &&
                                 (fslot_reg == SLOT_BITS'(g));
            svna_cell #(.KEY_BITS(KEY_BITS)) u_cell (
                .aclk, .aresetn,
                .probe_valid(probe_chain_reg[g]),
                .probe_key(key_reg),
                .load(load_vec[g]), .update(upd_vec[g]),
                .nx(in_reg[111:96]), .ny(in_reg[127:112]), .nz(in_reg[143:128]),
                .hit(hit_vec[g]), .acc(acc_vec[g]));
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            probe_chain_reg <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: if (s_tvalid) begin
                    in_reg   <= s_tdata;
                    qcnt_reg <= '0;
                    state_reg <= S_QUANT;
                end
                S_QUANT: begin
                    qcnt_reg <= qcnt_reg + 2'd1;
                    if (qcnt_reg == 2'd2) begin
                        vx_reg <= ix; vy_reg <= iy; vz_reg <= iz;
                        key_reg <= {ix, iy, iz};
                        found_reg <= 1'b0;
                        step_reg <= '0;
                        if (!(inx && iny && inz)) begin
                            st_reg <= ST_OUTSIDE;
                            state_reg <= S_OUT;
                        end else begin
                            probe_chain_reg <= CAPACITY'(1);
                            state_reg <= S_WALK;
                        end
                    end
                end
                S_WALK: begin
                    step_reg <= step_reg + 1'b1;
                    if (hit_vec[step_reg[SLOT_BITS-1:0]]) begin
                        found_reg <= 1'b1;
                        fslot_reg <= step_reg[SLOT_BITS-1:0];
                        st_reg <= ST_UPDATED;
                        probe_chain_reg <= '0;
                        state_reg <= S_WRITE;
                    end else if (step_reg == CNT_BITS'(CAPACITY - 1)) begin
                        probe_chain_reg <= '0;
                        st_reg <= (used_reg == CNT_BITS'(CAPACITY)) ? ST_FULL : ST_NEW;
                        fslot_reg <= used_reg[SLOT_BITS-1:0];
                        state_reg <= S_WRITE;
                    end else begin
                        probe_chain_reg <= probe_chain_reg << 1;
                    end
                end
                S_WRITE: begin
                    if (st_reg == ST_NEW) used_reg <= used_reg + 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT: if (m_tready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_WRITE) begin
            oslot_reg <= fslot_reg;
            if (st_reg == ST_NEW) begin
                oacc_reg.hits  <= 16'd1;
                oacc_reg.sum_x <= 32'(signed'(in_reg[111:96]));
                oacc_reg.sum_y <= 32'(signed'(in_reg[127:112]));
                oacc_reg.sum_z <= 32'(signed'(in_reg[143:128]));
            end else if (st_reg == ST_UPDATED) begin
                oacc_reg.hits  <= (acc_vec[fslot_reg].hits != 16'hffff) ?
                                  acc_vec[fslot_reg].hits + 16'd1 : 16'hffff;
                oacc_reg.sum_x <= sat_add(acc_vec[fslot_reg].sum_x, in_reg[111:96]);
                oacc_reg.sum_y <= sat_add(acc_vec[fslot_reg].sum_y, in_reg[127:112]);
                oacc_reg.sum_z <= sat_add(acc_vec[fslot_reg].sum_z, in_reg[143:128]);
            end else begin
                oacc_reg <= '0;
            end
        end
    end

    assign slot8 = ((st_reg == ST_NEW) || (st_reg == ST_UPDATED)) ?
                   8'(oslot_reg) : 8'd0;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata = {
        ((st_reg == ST_NEW) || (st_reg == ST_UPDATED)) ?
            {oacc_reg.sum_z, oacc_reg.sum_y, oacc_reg.sum_x, oacc_reg.hits} : 112'd0,
        (st_reg == ST_OUTSIDE) ? 30'd0 :
            {10'(vz_reg), 10'(vy_reg), 10'(vx_reg)},
        slot8, st_reg};

`ifndef SYNTH
    a_used_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= CNT_BITS'(CAPACITY)) else $error("fill count overflow");
    a_probe_one: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(probe_chain_reg)) else $error("probe token duplicated");
    a_new_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WRITE && st_reg == ST_NEW) |=> used_reg == $past(used_reg) + 1'b1)
        else $error("new voxel did not take a slot");
`endif
endmodule

// ===== rtl/svna_quant.sv =====
// Per-axis quantizer: (p - min) * inverse, integer part, range check.
// Two register stages; depends on svna_pkg.
module svna_quant
    import svna_pkg::*;
#(
    parameter int INDEX_BITS = 10
) (
    input  logic                  aclk,
    input  logic signed [31:0]    point,
    input  logic signed [31:0]    grid_min,
    input  logic [31:0]           inverse,
    input  logic [10:0]           cells,
    output logic [INDEX_BITS-1:0] index,
    output logic                  in_grid
);
    logic [31:0] diff_reg;
    logic        neg_reg;
    logic [63:0] prod_reg;
    logic        neg2_reg;
    logic        zinv_reg;
    logic [31:0] q;
    logic [16:0] lim;

    always_ff @(posedge aclk) begin
        diff_reg <= point - grid_min;
        neg_reg  <= (33'(point) - 33'(grid_min)) < 0;
        prod_reg <= 64'(diff_reg) * 64'(inverse);
        neg2_reg <= neg_reg;
        zinv_reg <= (inverse == 32'd0);
    end

    always_comb begin
        q = zinv_reg ? 32'd0 : prod_reg[63:32];
        lim = (17'(cells) < (17'd1 << INDEX_BITS)) ? 17'(cells)
            : (17'd1 << INDEX_BITS);
        in_grid = (zinv_reg || !neg2_reg) && (q < 32'(lim));
        index   = q[INDEX_BITS-1:0];
    end
endmodule

// ===== rtl/svna_cell.sv =====
// One table cell: holds a key, a valid flag and accumulators, compares the
// shared probe key when the probe token passed down the chain reaches it. Depends on svna_pkg.
module svna_cell
    import svna_pkg::*;
#(
    parameter int KEY_BITS = 30
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                probe_valid,
    input  logic [KEY_BITS-1:0] probe_key,
    input  logic                load,
    input  logic                update,
    input  logic signed [15:0]  nx,
    input  logic signed [15:0]  ny,
    input  logic signed [15:0]  nz,
    output logic                hit,
    output voxel_acc_t          acc
);
    logic                valid_reg;
    logic [KEY_BITS-1:0] key_reg;
    voxel_acc_t          acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end
        if (load) begin
            key_reg       <= probe_key;
            acc_reg.hits  <= 16'd1;
            acc_reg.sum_x <= 32'(nx);
            acc_reg.sum_y <= 32'(ny);
            acc_reg.sum_z <= 32'(nz);
        end else if (update) begin
            if (acc_reg.hits != 16'hffff) begin
                acc_reg.hits <= acc_reg.hits + 16'd1;
            end
            acc_reg.sum_x <= sat_add(acc_reg.sum_x, nx);
            acc_reg.sum_y <= sat_add(acc_reg.sum_y, ny);
            acc_reg.sum_z <= sat_add(acc_reg.sum_z, nz);
        end
    end

    assign hit = probe_valid && valid_reg && (key_reg == probe_key);
    assign acc = acc_reg;
endmodule
